[rtl/gram_schmidt_qr_decomposition_macros.svh]
// ----------------------------------------------------------------------------
// QR decomposition assertion macros
// Concurrent check wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAM_SCHMIDT_QR_DECOMPOSITION_MACROS_SVH
`define GRAM_SCHMIDT_QR_DECOMPOSITION_MACROS_SVH
`ifndef SYNTHESIS
`define GSQR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GSQR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GSQR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GSQR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/gsqr_pkg.sv]
// ----------------------------------------------------------------------------
// QR decomposition package
// Shared types, codes and saturation helper.
// ----------------------------------------------------------------------------
package gsqr_pkg;

  localparam int CW         = 4;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_READ   = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COL_BEGIN,
    ST_NRM_RD,
    ST_NRM_MUL,
    ST_NRM_ACC,
    ST_SQRT_LD,
    ST_SQRT,
    ST_DIAG,
    ST_QN_RD,
    ST_QN_LD,
    ST_QN_DIV,
    ST_QN_WR,
    ST_PAIR_BEGIN,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_PROJ,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_LOW_WR,
    ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_START,
    CMD_ACC_CLR,
    CMD_RD_PAIR,
    CMD_SQUARE,
    CMD_ACC_UNS,
    CMD_SQRT_LD,
    CMD_SQRT_STEP,
    CMD_DIAG,
    CMD_DIV_LD,
    CMD_DIV_STEP,
    CMD_Q_WR,
    CMD_DOT_MUL,
    CMD_ACC_SGN,
    CMD_PROJ,
    CMD_UPD_MUL,
    CMD_UPD_WR,
    CMD_LOW_WR
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e         op;
    logic [CW-1:0]   i;
    logic [CW-1:0]   j;
    logic [CW-1:0]   k;
    logic            host_wr;
    logic            host_rd;
    logic            out_load;
    kind_e           out_kind;
  } cmd_t;

  typedef struct packed {
    logic norm_zero;
  } sts_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic hi_same;
    hi_same = (&v[63:31]) | ~(|v[63:31]);
    if (hi_same) begin
      return v[31:0];
    end else if (v[63]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

[rtl/gsqr_dp.sv]
// ----------------------------------------------------------------------------
// QR decomposition datapath
// Column and triangle stores, multiplier, accumulator, square root and divider.
// ----------------------------------------------------------------------------
module gsqr_dp import gsqr_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [2:0]        host_row_i,
  input  logic [2:0]        host_col_i,
  input  logic              host_sel_i,
  input  logic [DATA_W-1:0] host_value_i,
  output kind_e             out_kind_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic              out_deficient_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] elem_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  logic [DATA_W-1:0] col_mem [DEPTH];
  logic [DATA_W-1:0] tri_mem [DEPTH];

  logic [DATA_W-1:0] ra_q, rb_q, tr_q;
  logic              rd_sel_q, rd_in_q;
  logic [63:0]       prod_q, acc_q, acc_d;
  logic [33:0]       rem_q;
  logic [31:0]       root_q;
  logic [47:0]       dvd_q;
  logic [30:0]       drem_q, norm_q;
  logic              dsign_q;
  logic [DATA_W-1:0] proj_q;
  logic              flag_q;
  kind_e             out_kind_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_def_q;

  logic              host_in;
  logic [AW-1:0]     host_addr, addr_ki, addr_kj;
  logic              cw_en, ra_en, rb_en, tw_en, tr_en;
  logic [AW-1:0]     cw_addr, ra_addr, tw_addr;
  logic [DATA_W-1:0] cw_data, tw_data;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_res;
  logic [64:0]        sum_u, sum_s;
  logic [35:0]        sq_sh, sq_trial;
  logic [31:0]        dv_sh;
  logic [31:0]        norm_full;
  logic [DATA_W-1:0]  q_val, upd_val, proj_val;
  logic [31:0]        div_mag;
  logic signed [48:0] upd_diff;

  assign host_in   = (32'(host_row_i) < MAX_ROWS) && (32'(host_col_i) < MAX_COLS);
  assign host_addr = elem_addr(CW'(host_row_i), CW'(host_col_i));
  assign addr_ki   = elem_addr(cmd_i.k, cmd_i.i);
  assign addr_kj   = elem_addr(cmd_i.k, cmd_i.j);

  assign norm_full = root_q[31] ? 32'h7FFF_FFFF : root_q;
  assign q_val     = sat32(dsign_q ? -$signed({16'b0, dvd_q}) : $signed({16'b0, dvd_q}));
  assign upd_diff  = $signed({{17{rb_q[31]}}, rb_q}) - $signed({prod_q[63], prod_q[63:16]});
  assign upd_val   = sat32(64'(upd_diff));
  assign proj_val  = sat32($signed({{16{acc_q[63]}}, acc_q[63:16]}));
  assign div_mag   = ra_q[31] ? (~ra_q + 32'd1) : ra_q;

  always_comb begin
    cw_en   = 1'b0;
    cw_addr = addr_ki;
    cw_data = q_val;
    ra_en   = 1'b0;
    ra_addr = addr_ki;
    rb_en   = 1'b0;
    tw_en   = 1'b0;
    tw_addr = elem_addr(cmd_i.i, cmd_i.i);
    tw_data = norm_full;
    tr_en   = 1'b0;
    if (cmd_i.host_wr && host_in) begin
      cw_en   = 1'b1;
      cw_addr = host_addr;
      cw_data = host_value_i;
    end
    if (cmd_i.host_rd && host_in) begin
      ra_en   = 1'b1;
      ra_addr = host_addr;
      tr_en   = 1'b1;
    end
    unique case (cmd_i.op)
      CMD_RD_PAIR: begin
        ra_en = 1'b1;
        rb_en = 1'b1;
      end
      CMD_Q_WR: begin
        cw_en   = 1'b1;
        cw_data = (norm_q == '0) ? '0 : q_val;
      end
      CMD_UPD_WR: begin
        cw_en   = 1'b1;
        cw_addr = addr_kj;
        cw_data = upd_val;
      end
      CMD_DIAG: begin
        tw_en = 1'b1;
      end
      CMD_PROJ: begin
        tw_en   = 1'b1;
        tw_addr = elem_addr(cmd_i.i, cmd_i.j);
        tw_data = proj_val;
      end
      CMD_LOW_WR: begin
        tw_en   = 1'b1;
        tw_addr = elem_addr(cmd_i.j, cmd_i.i);
        tw_data = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      col_mem[cw_addr] <= cw_data;
    end
    if (ra_en) begin
      ra_q <= col_mem[ra_addr];
    end
    if (rb_en) begin
      rb_q <= col_mem[addr_kj];
    end
    if (tw_en) begin
      tri_mem[tw_addr] <= tw_data;
    end
    if (tr_en) begin
      tr_q <= tri_mem[host_addr];
    end
  end

  always_comb begin
    mul_a = $signed(ra_q);
    unique case (cmd_i.op)
      CMD_DOT_MUL: mul_b = $signed(rb_q);
      CMD_UPD_MUL: mul_b = $signed(proj_q);
      default:     mul_b = $signed(ra_q);
    endcase
    mul_res = mul_a * mul_b;
  end

  assign sum_u    = {1'b0, acc_q} + {1'b0, prod_q};
  assign sum_s    = {acc_q[63], acc_q} + {prod_q[63], prod_q};
  assign sq_sh    = {rem_q, acc_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign dv_sh    = {drem_q, dvd_q[47]};

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.op)
      CMD_ACC_CLR:   acc_d = '0;
      CMD_ACC_UNS:   acc_d = sum_u[64] ? '1 : sum_u[63:0];
      CMD_ACC_SGN: begin
        if (sum_s[64] != sum_s[63]) begin
          acc_d = sum_s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          acc_d = sum_s[63:0];
        end
      end
      CMD_SQRT_STEP: acc_d = {acc_q[61:0], 2'b00};
      default:       acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    unique case (cmd_i.op)
      CMD_SQUARE, CMD_DOT_MUL, CMD_UPD_MUL: begin
        prod_q <= mul_res;
      end
      CMD_SQRT_LD: begin
        rem_q  <= '0;
        root_q <= '0;
      end
      CMD_SQRT_STEP: begin
        if (sq_sh >= sq_trial) begin
          rem_q  <= 34'(sq_sh - sq_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= sq_sh[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      CMD_DIAG: begin
        norm_q <= norm_full[30:0];
      end
      CMD_DIV_LD: begin
        dvd_q   <= {div_mag, 16'b0};
        drem_q  <= '0;
        dsign_q <= ra_q[31];
      end
      CMD_DIV_STEP: begin
        if (dv_sh >= {1'b0, norm_q}) begin
          drem_q <= 31'(dv_sh - {1'b0, norm_q});
          dvd_q  <= {dvd_q[46:0], 1'b1};
        end else begin
          drem_q <= dv_sh[30:0];
          dvd_q  <= {dvd_q[46:0], 1'b0};
        end
      end
      CMD_PROJ: begin
        proj_q <= proj_val;
      end
      default: begin
      end
    endcase
    if (cmd_i.host_rd) begin
      rd_sel_q <= host_sel_i;
      rd_in_q  <= host_in;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_def_q  <= flag_q;
      if (cmd_i.out_kind == KIND_DONE || !rd_in_q) begin
        out_value_q <= '0;
      end else begin
        out_value_q <= rd_sel_q ? tr_q : ra_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.op == CMD_START) begin
      flag_q <= 1'b0;
    end else if (cmd_i.op == CMD_DIAG && root_q == '0) begin
      flag_q <= 1'b1;
    end
  end

  assign sts_o.norm_zero = (norm_q == '0);
  assign out_kind_o      = out_kind_q;
  assign out_value_o     = out_value_q;
  assign out_deficient_o = out_def_q;

endmodule

[rtl/gsqr_ctrl.sv]
// ----------------------------------------------------------------------------
// QR decomposition controller
// Request handshake, configuration registers and decomposition sequencer.
// ----------------------------------------------------------------------------
module gsqr_ctrl import gsqr_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  op_e                  s_op_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,
  output logic                 cfg_ready_o,
  output cmd_t                 cmd_o,
  input  sts_t                 sts_i
);

  state_e          state_q, state_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d, m_q, m_d, n_q, n_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]   rows_q, cols_q;
  logic            out_valid_q, rd_pend_q;
  logic            out_free, accept, k_last, i_last, j_last;
  logic [CW-1:0]   m_clamp, n_lim, n_clamp;

  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && !rd_pend_q && out_free;
  assign accept    = s_valid_i && s_ready_o;
  assign k_last    = (k_q == m_q - CW'(1));
  assign i_last    = (i_q == n_q - CW'(1));
  assign j_last    = (j_q == n_q - CW'(1));
  assign cfg_ready_o = 1'b1;
  assign m_valid_o   = out_valid_q;

  always_comb begin
    if (rows_q == '0) begin
      m_clamp = CW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      m_clamp = CW'(MAX_ROWS);
    end else begin
      m_clamp = rows_q;
    end
    if (cols_q == '0) begin
      n_lim = CW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      n_lim = CW'(MAX_COLS);
    end else begin
      n_lim = cols_q;
    end
    n_clamp = (n_lim > m_clamp) ? m_clamp : n_lim;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    m_d     = m_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_op_i == OP_START) begin
          m_d     = m_clamp;
          n_d     = n_clamp;
          i_d     = '0;
          state_d = ST_COL_BEGIN;
        end
      end
      ST_COL_BEGIN: begin
        k_d     = '0;
        state_d = ST_NRM_RD;
      end
      ST_NRM_RD:  state_d = ST_NRM_MUL;
      ST_NRM_MUL: state_d = ST_NRM_ACC;
      ST_NRM_ACC: begin
        if (k_last) begin
          state_d = ST_SQRT_LD;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_NRM_RD;
        end
      end
      ST_SQRT_LD: begin
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = ST_DIAG;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIAG: begin
        k_d     = '0;
        state_d = ST_QN_RD;
      end
      ST_QN_RD: state_d = sts_i.norm_zero ? ST_QN_WR : ST_QN_LD;
      ST_QN_LD: begin
        cnt_d   = '0;
        state_d = ST_QN_DIV;
      end
      ST_QN_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_QN_WR;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_QN_WR: begin
        if (k_last) begin
          if (i_last) begin
            state_d = ST_DONE;
          end else begin
            j_d     = i_q + CW'(1);
            state_d = ST_PAIR_BEGIN;
          end
        end else begin
          k_d     = k_q + CW'(1);
          state_d = sts_i.norm_zero ? ST_QN_WR : ST_QN_RD;
        end
      end
      ST_PAIR_BEGIN: begin
        k_d     = '0;
        state_d = ST_DOT_RD;
      end
      ST_DOT_RD:  state_d = ST_DOT_MUL;
      ST_DOT_MUL: state_d = ST_DOT_ACC;
      ST_DOT_ACC: begin
        if (k_last) begin
          state_d = ST_PROJ;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_DOT_RD;
        end
      end
      ST_PROJ: begin
        k_d     = '0;
        state_d = ST_UPD_RD;
      end
      ST_UPD_RD:  state_d = ST_UPD_MUL;
      ST_UPD_MUL: state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        if (k_last) begin
          state_d = ST_LOW_WR;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_UPD_RD;
        end
      end
      ST_LOW_WR: begin
        if (j_last) begin
          i_d     = i_q + CW'(1);
          state_d = ST_COL_BEGIN;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = ST_PAIR_BEGIN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = CMD_IDLE;
    cmd_o.i        = i_q;
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.host_wr  = accept && (s_op_i == OP_WRITE);
    cmd_o.host_rd  = accept && (s_op_i == OP_READ);
    cmd_o.out_load = rd_pend_q || ((state_q == ST_DONE) && out_free);
    cmd_o.out_kind = rd_pend_q ? KIND_READ : KIND_DONE;
    unique case (state_q)
      ST_IDLE:       cmd_o.op = (accept && s_op_i == OP_START) ? CMD_START : CMD_IDLE;
      ST_COL_BEGIN,
      ST_PAIR_BEGIN: cmd_o.op = CMD_ACC_CLR;
      ST_NRM_RD,
      ST_QN_RD,
      ST_DOT_RD,
      ST_UPD_RD:     cmd_o.op = CMD_RD_PAIR;
      ST_NRM_MUL:    cmd_o.op = CMD_SQUARE;
      ST_NRM_ACC:    cmd_o.op = CMD_ACC_UNS;
      ST_SQRT_LD:    cmd_o.op = CMD_SQRT_LD;
      ST_SQRT:       cmd_o.op = CMD_SQRT_STEP;
      ST_DIAG:       cmd_o.op = CMD_DIAG;
      ST_QN_LD:      cmd_o.op = CMD_DIV_LD;
      ST_QN_DIV:     cmd_o.op = CMD_DIV_STEP;
      ST_QN_WR:      cmd_o.op = CMD_Q_WR;
      ST_DOT_MUL:    cmd_o.op = CMD_DOT_MUL;
      ST_DOT_ACC:    cmd_o.op = CMD_ACC_SGN;
      ST_PROJ:       cmd_o.op = CMD_PROJ;
      ST_UPD_MUL:    cmd_o.op = CMD_UPD_MUL;
      ST_UPD_WR:     cmd_o.op = CMD_UPD_WR;
      ST_LOW_WR:     cmd_o.op = CMD_LOW_WR;
      ST_DONE:       cmd_o.op = CMD_IDLE;
      default:       cmd_o.op = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      m_q         <= CW'(1);
      n_q         <= CW'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      m_q         <= m_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= cmd_o.host_rd;
      out_valid_q <= cmd_o.out_load ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CW'(8);
      cols_q <= CW'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROWS_USED: rows_q <= cfg_data_i;
        CFG_COLS_USED: cols_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/gram_schmidt_qr_decomposition.sv]
// Writes are stored at accept; a read registers the element, then the output register.
// Start runs per column c (m rows, n columns): norm accumulation and square root,
// normalization (48-step divider per element), and projection per later column pair.
// A column with zero norm skips the divider and writes zero Q elements.
// Reset clears the sequencer and deficient flag, sets the registers to 8 rows, 8 columns;
// the element stores stay undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// Modified Gram-Schmidt QR decomposition
// Loads A, orthonormalizes it in place into Q and builds R; elements read back.
// ----------------------------------------------------------------------------
`include "gram_schmidt_qr_decomposition_macros.svh"

module gram_schmidt_qr_decomposition import gsqr_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [39:0]          s_axis_tdata_i,  // row[2:0], col[5:3], value[37:6]
  input  logic [2:0]           s_axis_tuser_i,  // operation[1:0], matrix_select[2]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [39:0]          m_axis_tdata_o,  // read_value[31:0], rank_deficient[32]
  output logic                 m_axis_tuser_o,  // kind[0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i
);

  cmd_t              cmd;
  sts_t              sts;
  kind_e             out_kind;
  logic [DATA_W-1:0] out_value;
  logic              out_def;
  logic              in_read, in_start, out_done;

  gsqr_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_op_i      (op_e'(s_axis_tuser_i[1:0])),
    .s_ready_o   (s_axis_tready_o),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gsqr_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .host_row_i      (s_axis_tdata_i[2:0]),
    .host_col_i      (s_axis_tdata_i[5:3]),
    .host_sel_i      (s_axis_tuser_i[2]),
    .host_value_i    (s_axis_tdata_i[37:6]),
    .out_kind_o      (out_kind),
    .out_value_o     (out_value),
    .out_deficient_o (out_def)
  );

  assign m_axis_tdata_o = {7'b0, out_def, out_value};
  assign m_axis_tuser_o = out_kind;

  assign in_read  = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[1:0] == OP_READ);
  assign in_start = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[1:0] == OP_START);
  assign out_done = m_axis_tvalid_o && (m_axis_tuser_o == KIND_DONE);

  `GSQR_ASSERT_IMP(a_ready_out_free, clk_i, rst_ni, s_axis_tready_o, !m_axis_tvalid_o || m_axis_tready_i)
  `GSQR_ASSERT_NXT(a_read_answers, clk_i, rst_ni, in_read, ##1 m_axis_tvalid_o)
  `GSQR_ASSERT_NXT(a_start_busy, clk_i, rst_ni, in_start, !s_axis_tready_o)
  `GSQR_ASSERT_IMP(a_done_zero, clk_i, rst_ni, out_done, m_axis_tdata_o[31:0] == 32'd0)

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// QR decomposition block testbench
// Loads A over the request stream, starts modified Gram-Schmidt, reads Q and R
// back, checks every response against a fixed-point predictor or a directed value,
// across several row and column settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import gsqr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR = 8;
  localparam int NC = 8;
  localparam int NUM_ITEMS = 1750;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    op_e        op;
    logic       sel;
    logic [2:0] row;
    logic [2:0] col;
    logic [31:0] val;
  } req_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] val;
    logic        def;
  } rsp_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    req_t        rq;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [39:0] s_data = '0;
  logic [2:0] s_user = '0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic s_ready, m_valid, m_user, cfg_ready;
  logic [39:0] m_data;

  gram_schmidt_qr_decomposition uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("gram_schmidt_qr_decomposition test failed");
    $finish;
  end

  // predictor state
  int          q_store[NR*NC];
  int          r_store[NR*NC];
  bit          q_written[NR*NC];
  bit          r_written[NR*NC];
  logic        rank_def;
  logic [3:0]  rows_reg = 4'd8;
  logic [3:0]  cols_reg = 4'd8;
  rsp_t        pending[$];
  int          errors = 0;
  int          items = 0;
  int          burst_left = 0;

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic longint add_clip64(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void eff_size(output int m, output int n);
    m = rows_reg;
    n = cols_reg;
    if (m < 1) m = 1;
    if (m > NR) m = NR;
    if (n < 1) n = 1;
    if (n > NC) n = NC;
    if (n > m) n = m;
  endfunction

  function automatic void orthonormalize();
    int m, n, proj;
    longint unsigned acc, sq;
    longint x, q, a, dot, nrm;
    eff_size(m, n);
    rank_def = 1'b0;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < m; k++) begin
        x = q_store[k*NC+i];
        sq = x * x;
        acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
      end
      nrm = longint'(root64(acc));
      if (nrm > 64'sd2147483647) nrm = 64'sd2147483647;
      r_store[i*NC+i] = int'(nrm);
      r_written[i*NC+i] = 1'b1;
      for (int k = 0; k < m; k++) begin
        x = q_store[k*NC+i];
        q_store[k*NC+i] = (nrm == 0) ? 0 : clip32((x * 65536) / nrm);
        q_written[k*NC+i] = 1'b1;
      end
      if (nrm == 0) rank_def = 1'b1;
      for (int j = i + 1; j < n; j++) begin
        dot = 0;
        for (int k = 0; k < m; k++) begin
          q = q_store[k*NC+i];
          a = q_store[k*NC+j];
          dot = add_clip64(dot, q * a);
        end
        proj = clip32(dot >>> 16);
        for (int k = 0; k < m; k++) begin
          q = q_store[k*NC+i];
          a = q_store[k*NC+j];
          q_store[k*NC+j] = clip32(a - ((longint'(proj) * q) >>> 16));
          q_written[k*NC+j] = 1'b1;
        end
        r_store[i*NC+j] = proj;
        r_store[j*NC+i] = 0;
        r_written[i*NC+j] = 1'b1;
        r_written[j*NC+i] = 1'b1;
      end
    end
  endfunction

  function automatic bit predict(input req_t rq, output rsp_t rsp);
    int a;
    a = rq.row * NC + rq.col;
    rsp.def = rank_def;
    case (rq.op)
      OP_WRITE: begin
        q_store[a] = int'(rq.val);
        q_written[a] = 1'b1;
        return 1'b0;
      end
      OP_START: begin
        orthonormalize();
        rsp.kind = KIND_DONE;
        rsp.val = '0;
        rsp.def = rank_def;
        return 1'b1;
      end
      OP_READ: begin
        rsp.kind = KIND_READ;
        rsp.val = rq.sel ? r_store[a] : q_store[a];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_req(input req_t rq, input bit typed, input rsp_t fixed);
    rsp_t p;
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, rq.val, rq.col, rq.row};
    s_user  <= {rq.sel, rq.op};
    do @(posedge clk_i); while (!s_ready);
    burst_left--;
    if (rq.op != OP_IGNORE) items++;
    if (predict(rq, p)) pending.push_back(typed ? fixed : p);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS_USED) rows_reg = d;
    else if (idx == CFG_COLS_USED) cols_reg = d;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom;
      default: return 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
    endcase
  endfunction

  task automatic issue(input op_e op, input logic sel, input int r, input int c,
                       input logic [31:0] v);
    req_t rq;
    rsp_t none;
    rq.op = op;
    rq.sel = sel;
    rq.row = r[2:0];
    rq.col = c[2:0];
    rq.val = v;
    none = '{KIND_READ, '0, 1'b0};
    send_req(rq, 1'b0, none);
  endtask

  task automatic noise();
    int a;
    logic s;
    if ($urandom_range(0, 9) != 0) return;
    a = $urandom_range(0, NR*NC-1);
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: issue(OP_IGNORE, s, a / NC, a % NC, $urandom);
      1: if (s ? r_written[a] : q_written[a]) issue(OP_READ, s, a / NC, a % NC, $urandom);
      default: issue(OP_WRITE, s, a / NC, a % NC, pick_value());
    endcase
  endtask

  function automatic row_t d_req(input op_e op, input logic sel, input int r, input int c,
                                 input logic [31:0] v);
    row_t t;
    t.is_cfg = 1'b0;
    t.idx = '0;
    t.rq = '{op, sel, r[2:0], c[2:0], v};
    t.typed = 1'b0;
    t.rsp = '{KIND_READ, '0, 1'b0};
    return t;
  endfunction

  function automatic row_t d_exp(input op_e op, input logic sel, input int r, input int c,
                                 input kind_e k, input logic [31:0] v, input logic d);
    row_t t;
    t = d_req(op, sel, r, c, 32'h0);
    t.typed = 1'b1;
    t.rsp = '{k, v, d};
    return t;
  endfunction

  function automatic row_t d_cfg(input logic [1:0] idx, input logic [3:0] d);
    row_t t;
    t = d_req(OP_IGNORE, 1'b0, 0, 0, {28'h0, d});
    t.is_cfg = 1'b1;
    t.idx = idx;
    return t;
  endfunction

  row_t plan[$];

  initial begin
    int m, n, cnt, r, c, a;
    bit zero_col, started;
    logic s;
    rank_def = 1'b0;
    plan = '{
      d_cfg(CFG_ROWS_USED, 4'd1), d_cfg(CFG_COLS_USED, 4'd1),
      d_req(OP_WRITE, 1'b0, 0, 0, 32'h0),
      d_exp(OP_START, 1'b0, 0, 0, KIND_DONE, 32'h0, 1'b1),
      d_exp(OP_READ, 1'b0, 0, 0, KIND_READ, 32'h0, 1'b1),
      d_exp(OP_READ, 1'b1, 0, 0, KIND_READ, 32'h0, 1'b1),
      d_req(OP_IGNORE, 1'b1, 7, 7, 32'hFFFF_FFFF),
      d_req(OP_WRITE, 1'b1, 0, 0, 32'h8000_0000),
      d_exp(OP_START, 1'b1, 0, 0, KIND_DONE, 32'h0, 1'b0),
      d_req(OP_READ, 1'b0, 0, 0, 32'h0),
      d_exp(OP_READ, 1'b1, 0, 0, KIND_READ, 32'h7FFF_FFFF, 1'b0),
      d_req(OP_WRITE, 1'b0, 0, 0, 32'h7FFF_FFFF),
      d_exp(OP_START, 1'b0, 0, 0, KIND_DONE, 32'h0, 1'b0),
      d_exp(OP_READ, 1'b1, 0, 0, KIND_READ, 32'h7FFF_FFFF, 1'b0),
      d_exp(OP_READ, 1'b0, 0, 0, KIND_READ, 32'h0001_0000, 1'b0),
      d_cfg(CFG_ROWS_USED, 4'd2), d_cfg(CFG_COLS_USED, 4'd2),
      d_req(OP_WRITE, 1'b0, 0, 0, 32'h0001_0000),
      d_req(OP_WRITE, 1'b0, 1, 0, 32'h0),
      d_req(OP_WRITE, 1'b0, 0, 1, 32'h0002_0000),
      d_req(OP_WRITE, 1'b0, 1, 1, 32'h0003_0000),
      d_exp(OP_START, 1'b0, 0, 0, KIND_DONE, 32'h0, 1'b0),
      d_exp(OP_READ, 1'b1, 1, 0, KIND_READ, 32'h0, 1'b0),
      d_req(OP_READ, 1'b1, 0, 1, 32'h0),
      d_req(OP_READ, 1'b0, 1, 1, 32'h0),
      d_req(OP_WRITE, 1'b0, 7, 7, 32'hFFFF_FFFF),
      d_exp(OP_READ, 1'b0, 7, 7, KIND_READ, 32'hFFFF_FFFF, 1'b0)
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].rq.val[3:0]);
      end else begin
        send_req(plan[i].rq, plan[i].typed, plan[i].rsp);
      end
    end

    while (items < NUM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0: begin write_reg(CFG_ROWS_USED, 4'd8); write_reg(CFG_COLS_USED, 4'd8); end
        1: begin
          write_reg(CFG_ROWS_USED, 4'($urandom));
          write_reg(CFG_COLS_USED, 4'($urandom));
        end
        2: begin write_reg(CFG_ROWS_USED, 4'd0); write_reg(CFG_COLS_USED, 4'd15); end
        default: begin
          write_reg(CFG_ROWS_USED, 4'($urandom_range(1, 4)));
          write_reg(CFG_COLS_USED, 4'($urandom_range(1, 4)));
        end
      endcase
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 4'($urandom));
      eff_size(m, n);
      repeat ($urandom_range(1, 3)) begin
        started = ($urandom_range(0, 7) != 0);
        for (int cc = 0; cc < n; cc++) begin
          zero_col = ($urandom_range(0, 9) == 0);
          for (int rr = 0; rr < m; rr++) begin
            noise();
            issue(OP_WRITE, 1'($urandom_range(0, 1)), rr, cc,
                  zero_col ? 32'h0 : pick_value());
          end
        end
        if (started) issue(OP_START, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        cnt = $urandom_range(2, (m*n + n*n > 24) ? 24 : m*n + n*n);
        repeat (cnt) begin
          noise();
          s = 1'($urandom_range(0, 1));
          if (s) begin
            r = $urandom_range(0, n-1);
            c = $urandom_range(0, n-1);
          end else begin
            r = $urandom_range(0, m-1);
            c = $urandom_range(0, n-1);
          end
          a = r * NC + c;
          if (s && !r_written[a]) s = 1'b0;
          if (!s && !q_written[a]) continue;
          issue(OP_READ, s, r, c, $urandom);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("gram_schmidt_qr_decomposition test passed");
    end else begin
      $display("gram_schmidt_qr_decomposition test failed");
    end
    $finish;
  end

  int stall_mode = 0;
  int stall_left = 0;
  int mode_left = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 2);
    end
    mode_left--;
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_ready <= 1'b0;
        end else begin
          m_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && m_valid && m_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected response kind %0b data %h", $time, m_user, m_data);
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_user !== e.kind) begin
          $display("%0t: kind expected %0b actual %0b", $time, e.kind, m_user);
          errors++;
        end
        if (m_data[31:0] !== e.val) begin
          $display("%0t: read_value expected %h actual %h", $time, e.val, m_data[31:0]);
          errors++;
        end
        if (m_data[32] !== e.def) begin
          $display("%0t: rank_deficient expected %0b actual %0b", $time, e.def, m_data[32]);
          errors++;
        end
      end
    end
  end

endmodule
